// ----- hdl/salc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int LINE_SIZE  = 64;
  localparam int SET_COUNT  = 32;
  localparam int WAY_COUNT  = 4;
  localparam int ADDR_BITS  = 32;

  localparam int IN_ADDR_BITS = 32;
  localparam int COUNT_BITS   = 32;

  localparam int OFFSET_BITS = $clog2(LINE_SIZE);
  localparam int SET_LOG     = $clog2(SET_COUNT);
  localparam int SET_BITS    = (SET_COUNT > 1) ? SET_LOG : 1;
  localparam int TAG_LSB     = OFFSET_BITS + SET_LOG;
  localparam int TAG_BITS    = ADDR_BITS - TAG_LSB;
  localparam int WAY_BITS    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int RANK_BITS   = WAY_BITS;

  localparam logic [63:0] ADDR_MASK =
    (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] SET_MASK = 64'(SET_COUNT - 1);

  typedef logic [WAY_COUNT-1:0][TAG_BITS-1:0]  tag_row_t;
  typedef logic [WAY_COUNT-1:0][RANK_BITS-1:0] rank_row_t;
  typedef logic [WAY_COUNT-1:0]                valid_row_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_res_t;

endpackage

`default_nettype wire

// ----- hdl/salc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/salc_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none

module salc_lookup (
  input  wire salc_pkg::tag_row_t                   tag_row,
  input  wire salc_pkg::valid_row_t                 valid_row,
  input  wire salc_pkg::rank_row_t                  rank_row,
  input  wire logic [salc_pkg::TAG_BITS-1:0]        req_tag,
  output salc_pkg::lookup_res_t                     res,
  output salc_pkg::tag_row_t                        tag_row_next,
  output salc_pkg::valid_row_t                      valid_row_next,
  output salc_pkg::rank_row_t                       rank_row_next
);

  logic                           hit;
  logic                           found_empty;
  logic [salc_pkg::WAY_BITS-1:0]  hit_way;
  logic [salc_pkg::WAY_BITS-1:0]  empty_way;
  logic [salc_pkg::WAY_BITS-1:0]  lru_way;
  logic [salc_pkg::WAY_BITS-1:0]  victim;
  logic [salc_pkg::RANK_BITS-1:0] old_rank;

  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    found_empty = 1'b0;
    empty_way   = '0;
    lru_way     = '0;
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      if (!hit && valid_row[w] && tag_row[w] == req_tag) begin
        hit     = 1'b1;
        hit_way = salc_pkg::WAY_BITS'(w);
      end
      if (!found_empty && !valid_row[w]) begin
        found_empty = 1'b1;
        empty_way   = salc_pkg::WAY_BITS'(w);
      end
      if (rank_row[w] == salc_pkg::RANK_BITS'(salc_pkg::WAY_COUNT - 1)) begin
        lru_way = salc_pkg::WAY_BITS'(w);
      end
    end

    if (hit) begin
      victim = hit_way;
    end else if (found_empty) begin
      victim = empty_way;
    end else begin
      victim = lru_way;
    end

    res.hit     = hit;
    res.evicted = !hit && !found_empty;

    old_rank = rank_row[victim];
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      if (salc_pkg::WAY_BITS'(w) == victim) begin
        rank_row_next[w] = '0;
      end else if (rank_row[w] < old_rank) begin
        rank_row_next[w] = rank_row[w] + salc_pkg::RANK_BITS'(1);
      end else begin
        rank_row_next[w] = rank_row[w];
      end
    end

    tag_row_next           = tag_row;
    tag_row_next[victim]   = req_tag;
    valid_row_next         = valid_row;
    valid_row_next[victim] = 1'b1;
  end

endmodule

`default_nettype wire

// ----- hdl/set_assoc_lru_cache_model_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                                  | handshake
// --------+----------------------------------------+-------------------------
// input   | byte_address                           | in_valid / in_ready
// output  | hit, evicted, miss_total               | out_valid / out_ready
//
// One access per cycle while the output is not stalled; the result is registered out of the compare stage.
// The input transfer reads the set's tag row from RAM; the next cycle compares all ways,
// updates LRU ranks, valid bits and the miss counter, and writes the row back.
// A back-to-back access to the same set takes the written row from a bypass.
// Reset clears valid bits, sets ranks to way order and zeroes the counter.
// A stalled output holds the compare stage; input is taken while it can drain.

module set_assoc_lru_cache_model_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [salc_pkg::IN_ADDR_BITS-1:0] byte_address,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   hit,
  output logic                                   evicted,
  output logic      [salc_pkg::COUNT_BITS-1:0]   miss_total
);

  logic                            in_fire;
  logic                            s1_fire;
  logic [63:0]                     addr_ext;
  logic [salc_pkg::SET_BITS-1:0]   in_set;
  logic [salc_pkg::TAG_BITS-1:0]   in_tag;

  logic                            s1_valid;
  logic [salc_pkg::SET_BITS-1:0]   s1_set;
  logic [salc_pkg::TAG_BITS-1:0]   s1_tag;
  logic                            byp;
  salc_pkg::tag_row_t              byp_row;

  salc_pkg::tag_row_t              ram_row;
  salc_pkg::tag_row_t              cur_row;
  salc_pkg::tag_row_t              row_next;
  salc_pkg::valid_row_t            valid_next;
  salc_pkg::rank_row_t             rank_next;
  salc_pkg::lookup_res_t           res;

  salc_pkg::valid_row_t            valid_bits [salc_pkg::SET_COUNT];
  salc_pkg::rank_row_t             ranks      [salc_pkg::SET_COUNT];
  logic [salc_pkg::COUNT_BITS-1:0] misses;
  logic [salc_pkg::COUNT_BITS-1:0] misses_next;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  assign addr_ext = {32'b0, byte_address} & salc_pkg::ADDR_MASK;
  assign in_set   = salc_pkg::SET_BITS'((addr_ext >> salc_pkg::OFFSET_BITS)
                                        & salc_pkg::SET_MASK);
  assign in_tag   = salc_pkg::TAG_BITS'(addr_ext >> salc_pkg::TAG_LSB);

  salc_ram #(
    .WIDTH ($bits(salc_pkg::tag_row_t)),
    .DEPTH (salc_pkg::SET_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_set),
    .wr_data (row_next),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (ram_row)
  );

  assign cur_row = byp ? byp_row : ram_row;

  salc_lookup u_lookup (
    .tag_row        (cur_row),
    .valid_row      (valid_bits[s1_set]),
    .rank_row       (ranks[s1_set]),
    .req_tag        (s1_tag),
    .res            (res),
    .tag_row_next   (row_next),
    .valid_row_next (valid_next),
    .rank_row_next  (rank_next)
  );

  always_comb begin
    misses_next = misses;
    if (!res.hit && misses != '1) begin
      misses_next = misses + salc_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      misses    <= '0;
      for (int s = 0; s < salc_pkg::SET_COUNT; s++) begin
        valid_bits[s] <= '0;
        for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
          ranks[s][w] <= salc_pkg::RANK_BITS'(w);
        end
      end
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid          <= 1'b1;
        misses             <= misses_next;
        valid_bits[s1_set] <= valid_next;
        ranks[s1_set]      <= rank_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_set  <= in_set;
      s1_tag  <= in_tag;
      byp     <= s1_fire && (s1_set == in_set);
      byp_row <= row_next;
    end
    if (s1_fire) begin
      hit        <= res.hit;
      evicted    <= res.evicted;
      miss_total <= misses_next;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_set_assoc_lru_cache_model_top.sv -----
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model_top;

  localparam int PROBE_ROWS     = 18;
  localparam int RANDOM_ITEMS   = 400;
  localparam int HOLD_CYCLES    = 100;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOT_TAGS       = 6;
  localparam int HOT_SETS       = 3;

  typedef struct packed {
    logic                              hit;
    logic                              evicted;
    logic [salc_pkg::COUNT_BITS-1:0]   miss_total;
  } access_result_t;

  typedef struct packed {
    logic [salc_pkg::IN_ADDR_BITS-1:0] addr;
    logic                              typed;
    logic                              hit;
    logic                              evicted;
    logic [salc_pkg::COUNT_BITS-1:0]   miss_total;
  } probe_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [salc_pkg::IN_ADDR_BITS-1:0] byte_address = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              hit;
  logic                              evicted;
  logic [salc_pkg::COUNT_BITS-1:0]   miss_total;

  logic                              row_typed = 1'b0;
  logic                              row_hit = 1'b0;
  logic                              row_evicted = 1'b0;
  logic [salc_pkg::COUNT_BITS-1:0]   row_miss_total = '0;

  salc_pkg::tag_row_t                cache_tags [salc_pkg::SET_COUNT];
  salc_pkg::valid_row_t              cache_valid [salc_pkg::SET_COUNT];
  salc_pkg::rank_row_t               cache_rank [salc_pkg::SET_COUNT];
  logic [salc_pkg::COUNT_BITS-1:0]   pred_misses;

  access_result_t                    expected_results [$];
  probe_row_t                        probe_rows [PROBE_ROWS];
  logic [salc_pkg::TAG_BITS-1:0]     hot_tags [HOT_TAGS];
  logic [salc_pkg::SET_BITS-1:0]     hot_sets [HOT_SETS];

  int fault_count   = 0;
  int access_count  = 0;
  int hit_count     = 0;
  int evict_count   = 0;
  int idle_cycles   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int no_idle_left [2] = '{0, 0};

  set_assoc_lru_cache_model_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_address(byte_address),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .evicted     (evicted),
    .miss_total  (miss_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_gap(input int side);
    int r;
    if (no_idle_left[side] > 0) begin
      no_idle_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_idle_left[side] = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic access_result_t predict_lookup(
    input logic [salc_pkg::IN_ADDR_BITS-1:0] addr
  );
    logic [63:0]                    line;
    int                             set_idx;
    logic [salc_pkg::TAG_BITS-1:0]  tag;
    int                             victim;
    logic [salc_pkg::RANK_BITS-1:0] old_rank;
    access_result_t                 res;
    line    = (64'(addr) & salc_pkg::ADDR_MASK) / 64'(salc_pkg::LINE_SIZE);
    set_idx = int'(line % 64'(salc_pkg::SET_COUNT));
    tag     = salc_pkg::TAG_BITS'(line / 64'(salc_pkg::SET_COUNT));
    victim  = -1;
    res     = '0;
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      if (victim < 0 && cache_valid[set_idx][w] && cache_tags[set_idx][w] == tag) begin
        victim = w;
      end
    end
    if (victim >= 0) begin
      res.hit = 1'b1;
    end else begin
      if (pred_misses != '1) pred_misses = pred_misses + salc_pkg::COUNT_BITS'(1);
      for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
        if (victim < 0 && !cache_valid[set_idx][w]) victim = w;
      end
      if (victim < 0) begin
        res.evicted = 1'b1;
        for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
          if (cache_rank[set_idx][w] == salc_pkg::RANK_BITS'(salc_pkg::WAY_COUNT - 1)) begin
            victim = w;
          end
        end
      end
      cache_tags[set_idx][victim]  = tag;
      cache_valid[set_idx][victim] = 1'b1;
    end
    old_rank = cache_rank[set_idx][victim];
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      if (cache_rank[set_idx][w] < old_rank) begin
        cache_rank[set_idx][w] = cache_rank[set_idx][w] + salc_pkg::RANK_BITS'(1);
      end
    end
    cache_rank[set_idx][victim] = '0;
    res.miss_total = pred_misses;
    return res;
  endfunction

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    access_result_t pred;
    access_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = predict_lookup(byte_address);
        access_count++;
        if (pred.hit) hit_count++;
        if (pred.evicted) evict_count++;
        if (row_typed) pred = '{row_hit, row_evicted, row_miss_total};
        expected_results.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_fault($sformatf("result with no pending access: hit=%0b evicted=%0b mt=%0d",
                                 hit, evicted, miss_total));
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit || evicted !== want.evicted ||
              miss_total !== want.miss_total) begin
            report_fault($sformatf("hit=%0b/%0b evicted=%0b/%0b mt=%0d/%0d (actual/expected)",
                                   hit, want.hit, evicted, want.evicted,
                                   miss_total, want.miss_total));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      stall = idle_gap(1);
      if (stall > 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_access(input probe_row_t row);
    int g;
    in_valid       <= 1'b1;
    byte_address   <= row.addr;
    row_typed      <= row.typed;
    row_hit        <= row.hit;
    row_evicted    <= row.evicted;
    row_miss_total <= row.miss_total;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = idle_gap(0);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    probe_row_t          row;
    logic [63:0]         addr64;
    probe_rows = '{
      '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd1},
      '{32'h0000_003F, 1'b1, 1'b1, 1'b0, 32'd1},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd2},
      '{32'hFFFF_FFC0, 1'b1, 1'b1, 1'b0, 32'd2},
      '{32'h0000_0800, 1'b1, 1'b0, 1'b0, 32'd3},
      '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 32'd4},
      '{32'h0000_1800, 1'b1, 1'b0, 1'b0, 32'd5},
      '{32'h0000_2000, 1'b1, 1'b0, 1'b1, 32'd6},
      '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 32'd7},
      '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0800, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_07C0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{32'h0000_1800, 1'b0, 1'b0, 1'b0, 32'd0}
    };
    for (int s = 0; s < salc_pkg::SET_COUNT; s++) begin
      cache_tags[s]  = '0;
      cache_valid[s] = '0;
      for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
        cache_rank[s][w] = salc_pkg::RANK_BITS'(w);
      end
    end
    pred_misses = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PROBE_ROWS; i++) send_access(probe_rows[i]);
    pause_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        for (int k = 0; k < HOT_TAGS; k++) hot_tags[k] = salc_pkg::TAG_BITS'($urandom);
        for (int k = 0; k < HOT_SETS; k++) begin
          hot_sets[k] = salc_pkg::SET_BITS'($urandom_range(0, salc_pkg::SET_COUNT - 1));
        end
      end
      if (n == 150) begin
        hold_requests++;
        no_idle_left[0] = 60;
      end
      if (n == 300) pause_until_drained();
      row = '0;
      if ($urandom_range(0, 99) < 80) begin
        addr64 = (64'(hot_tags[$urandom_range(0, HOT_TAGS - 1)]) << salc_pkg::TAG_LSB)
               | (64'(hot_sets[$urandom_range(0, HOT_SETS - 1)]) << salc_pkg::OFFSET_BITS)
               | (64'($urandom) & 64'(salc_pkg::LINE_SIZE - 1));
        row.addr = salc_pkg::IN_ADDR_BITS'(addr64);
      end else begin
        row.addr = salc_pkg::IN_ADDR_BITS'($urandom);
      end
      send_access(row);
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d evictions",
             access_count, hit_count, access_count - hit_count, evict_count);
    $display("Hot-set reuse, random addresses, a %0d-cycle output stall and drain pauses",
             HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
